// ===== hw/rtl/mcpe_pkg.sv =====
// Shared types and constants of the MQTT control packet encoder.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mcpe_pkg;

  // Width of the string lengths carried in a start item.
  localparam int unsigned LEN_W = 16;
  // Largest remaining length is 12 + 3 * (2**LEN_W - 1) + 4, which fits in LEN_W + 2 bits.
  // The remaining-length encoder handles up to three 7-bit groups (LEN_W <= 19).
  localparam int unsigned REM_W = LEN_W + 2;
  localparam int unsigned PID_W = 16;

  // Command queue between front and back end. Depth must be a power of two.
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ALIVE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAGS      = 1'b1;
  localparam logic [15:0] KEEP_ALIVE_RST = 16'd60;
  localparam logic [7:0]  FLAGS_RST      = 8'hC2;

  // Fixed header bytes
  localparam logic [7:0] HDR_CONNECT = 8'h10;
  localparam logic [7:0] HDR_SUB     = 8'h82;
  localparam logic [7:0] HDR_UNSUB   = 8'hA2;
  localparam logic [7:0] HDR_PUB     = 8'h30;
  localparam logic [7:0] HDR_DISC    = 8'hE0;
  localparam logic [7:0] HDR_PING    = 8'hC0;

  typedef logic [LEN_W-1:0]     mcpe_len_t;
  typedef logic [REM_W-1:0]     mcpe_rem_t;
  typedef logic [PID_W-1:0]     mcpe_pid_t;
  typedef logic [CMD_PTR_W-1:0] mcpe_qptr_t;
  typedef logic [CMD_PTR_W:0]   mcpe_qcnt_t;

  localparam mcpe_qcnt_t CMD_FULL = mcpe_qcnt_t'(CMD_DEPTH);

  // Packet kind codes of a start item
  typedef enum logic [2:0] {
    KIND_CONNECT = 3'd0,
    KIND_SUB     = 3'd1,
    KIND_UNSUB   = 3'd2,
    KIND_PUB     = 3'd3,
    KIND_DISC    = 3'd4,
    KIND_PING    = 3'd5
  } mcpe_kind_e;

  // What the back end emits first for one accepted item
  typedef enum logic [2:0] {
    H_ERR,
    H_DATA,
    H_CONN,
    H_SUB,
    H_UNSUB,
    H_PUB,
    H_DISC,
    H_PING
  } mcpe_head_e;

  // One command: all output bytes caused by one input item
  typedef struct packed {
    mcpe_head_e  head;
    logic [7:0]  dbyte;    // pass-through string byte
    logic [1:0]  qos;      // saturated QoS
    mcpe_rem_t   rem;      // remaining length of the packet
    mcpe_len_t   len1;     // first string length prefix
    logic        ext_en;   // extra length prefix follows
    mcpe_len_t   ext_len;
    logic        qos_en;   // QoS byte follows
    logic        pid_en;   // packet identifier follows
    mcpe_pid_t   pid;
    logic        last;     // final byte of this command ends the packet
  } mcpe_cmd_t;

  typedef struct packed {
    logic [15:0] keep_alive;
    logic [7:0]  flags;
  } mcpe_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mqtt_control_packet_encoder.sv =====
// MQTT 3.1.1 control packet encoder. A start item (req_type 0) opens a CONNECT, SUBSCRIBE,
// UNSUBSCRIBE, PUBLISH, DISCONNECT or PINGREQ packet; data items (req_type 1) carry the
// string bytes in packet order, and the block inserts headers, remaining length, length
// prefixes, QoS byte and packet identifier around them, flagging the final byte with last.
// A data item while no string is open yields a single error byte. Every item takes one
// input cycle while full is low: the front end writes any command into a 4-entry queue.
// The back-end sequencer emits one byte per cycle while its output buffer has room: a data
// or error item yields 1 to 3 bytes (a byte that ends a string also carries the next
// length prefix, the QoS byte or the packet identifier), a start item 2 to 18 and an
// unknown kind none; full rises while the queue holds four commands the sequencer has not
// reached. An item's first byte passes through the queue, cur_q and the output buffer.
// keep_alive_seconds and connect_flags are read live and must be written while idle.
// Depends on mcpe_pkg, mcpe_front, mcpe_cmd_queue and mcpe_back.
`timescale 1ns / 1ps
`default_nettype none

module mqtt_control_packet_encoder (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // input item
  input  wire                             push,
  output logic                            full,
  input  wire                             req_type_i,
  input  wire  [2:0]                      packet_kind_i,
  input  wire  [mcpe_pkg::LEN_W-1:0]      first_len_i,
  input  wire  [mcpe_pkg::LEN_W-1:0]      second_len_i,
  input  wire  [mcpe_pkg::LEN_W-1:0]      third_len_i,
  input  wire  [1:0]                      qos_level_i,
  input  wire  [7:0]                      data_byte_i,
  // result item
  output logic                            empty,
  input  wire                             pop,
  output logic [7:0]                      out_byte_o,
  output logic                            last_o,
  output logic                            error_o,
  // configuration
  input  wire                             cfg_we_i,
  input  wire  [mcpe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [mcpe_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  mcpe_pkg::mcpe_cfg_t cfg_q;
  mcpe_pkg::mcpe_cmd_t cmd_w, cmd_r;
  logic                accept, cmd_wr, cmd_valid, cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.keep_alive <= mcpe_pkg::KEEP_ALIVE_RST;
      cfg_q.flags      <= mcpe_pkg::FLAGS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcpe_pkg::CFG_KEEP_ALIVE: cfg_q.keep_alive <= cfg_data_i[15:0];
        mcpe_pkg::CFG_FLAGS:      cfg_q.flags      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  mcpe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .req_type_i    (req_type_i),
    .packet_kind_i (packet_kind_i),
    .first_len_i   (first_len_i),
    .second_len_i  (second_len_i),
    .third_len_i   (third_len_i),
    .qos_level_i   (qos_level_i),
    .data_byte_i   (data_byte_i),
    .cmd_wr_o      (cmd_wr),
    .cmd_o         (cmd_w)
  );

  mcpe_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_wr),
    .wdata_i (cmd_w),
    .full_o  (full),
    .rd_i    (cmd_pop),
    .valid_o (cmd_valid),
    .rdata_o (cmd_r)
  );

  mcpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_r),
    .cmd_pop_o   (cmd_pop),
    .cfg_i       (cfg_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mcpe_front.sv =====
// Front end: accepts items, tracks packet progress and turns each item into one command,
// but for a start item of unknown kind, which gives none. Depends on mcpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcpe_front (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      accept_i,
  input  wire                      req_type_i,
  input  wire  [2:0]               packet_kind_i,
  input  wire  mcpe_pkg::mcpe_len_t first_len_i,
  input  wire  mcpe_pkg::mcpe_len_t second_len_i,
  input  wire  mcpe_pkg::mcpe_len_t third_len_i,
  input  wire  [1:0]               qos_level_i,
  input  wire  [7:0]               data_byte_i,
  output logic                     cmd_wr_o,
  output mcpe_pkg::mcpe_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CID,
    PH_USER,
    PH_PASS,
    PH_TOPIC,
    PH_MSG
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [2:0]          kind_q, kind_d;
  mcpe_pkg::mcpe_len_t left_q, left_d;
  mcpe_pkg::mcpe_len_t sec_q, sec_d;
  mcpe_pkg::mcpe_len_t thr_q, thr_d;
  logic [1:0]          qos_q, qos_d;
  mcpe_pkg::mcpe_pid_t pid_q, pid_d;

  // Settle: what follows when the current string is exhausted
  phase_e              s_ph;
  logic [2:0]          s_kind;
  logic [1:0]          s_qos;
  mcpe_pkg::mcpe_len_t s_sec, s_thr;
  phase_e              s_ph_next;
  mcpe_pkg::mcpe_len_t s_left;
  logic                s_ext_en;
  mcpe_pkg::mcpe_len_t s_ext_len;
  logic                s_qos_en, s_pid_en, s_last;
  logic                use_settle;

  logic [1:0]          qos_sat;
  mcpe_pkg::mcpe_len_t left_m;
  mcpe_pkg::mcpe_rem_t r1, r2, r2c, r3c;
  logic                cmd_wr;
  mcpe_pkg::mcpe_cmd_t cmd;

  assign qos_sat = (qos_level_i == 2'd3) ? 2'd2 : qos_level_i;
  assign left_m  = left_q - 1'b1;

  assign r1  = mcpe_pkg::mcpe_rem_t'(first_len_i);
  assign r2  = mcpe_pkg::mcpe_rem_t'(second_len_i);
  // empty username / password fields are not sent and not counted
  assign r2c = (second_len_i != '0) ? r2 + mcpe_pkg::mcpe_rem_t'(2) : '0;
  assign r3c = (third_len_i != '0)
             ? mcpe_pkg::mcpe_rem_t'(third_len_i) + mcpe_pkg::mcpe_rem_t'(2) : '0;

  always_comb begin
    s_ph_next = PH_IDLE;
    s_left    = '0;
    s_ext_en  = 1'b0;
    s_ext_len = '0;
    s_qos_en  = 1'b0;
    s_pid_en  = 1'b0;
    s_last    = 1'b0;
    unique case (s_ph)
      PH_CID: begin
        if (s_sec != '0) begin
          s_ext_en  = 1'b1;
          s_ext_len = s_sec;
          s_ph_next = PH_USER;
          s_left    = s_sec;
        end else if (s_thr != '0) begin
          s_ext_en  = 1'b1;
          s_ext_len = s_thr;
          s_ph_next = PH_PASS;
          s_left    = s_thr;
        end else begin
          s_last = 1'b1;
        end
      end
      PH_USER: begin
        if (s_thr != '0) begin
          s_ext_en  = 1'b1;
          s_ext_len = s_thr;
          s_ph_next = PH_PASS;
          s_left    = s_thr;
        end else begin
          s_last = 1'b1;
        end
      end
      PH_TOPIC: begin
        if (s_kind == mcpe_pkg::KIND_SUB) begin
          s_qos_en = 1'b1;
          s_last   = 1'b1;
        end else if (s_kind == mcpe_pkg::KIND_PUB) begin
          s_pid_en = (s_qos != 2'd0);
          if (s_sec != '0) begin
            s_ph_next = PH_MSG;
            s_left    = s_sec;
          end else begin
            s_last = 1'b1;
          end
        end else begin
          s_last = 1'b1;
        end
      end
      default: s_last = 1'b1;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    kind_d     = kind_q;
    left_d     = left_q;
    sec_d      = sec_q;
    thr_d      = thr_q;
    qos_d      = qos_q;
    pid_d      = pid_q;
    cmd        = '0;
    cmd_wr     = 1'b0;
    use_settle = 1'b0;
    s_ph       = PH_IDLE;
    s_kind     = kind_q;
    s_qos      = qos_q;
    s_sec      = sec_q;
    s_thr      = thr_q;

    if (!req_type_i) begin
      // start item: any unfinished packet is dropped
      kind_d   = packet_kind_i;
      qos_d    = qos_sat;
      sec_d    = second_len_i;
      thr_d    = third_len_i;
      phase_d  = PH_IDLE;
      left_d   = '0;
      s_kind   = packet_kind_i;
      s_qos    = qos_sat;
      s_sec    = second_len_i;
      s_thr    = third_len_i;
      cmd.len1 = first_len_i;
      unique case (packet_kind_i) inside
        mcpe_pkg::KIND_CONNECT: begin
          cmd.head = mcpe_pkg::H_CONN;
          cmd.rem  = mcpe_pkg::mcpe_rem_t'(12) + r1 + r2c + r3c;
          cmd_wr   = 1'b1;
          if (first_len_i != '0) begin
            phase_d = PH_CID;
            left_d  = first_len_i;
          end else begin
            s_ph       = PH_CID;
            use_settle = 1'b1;
          end
        end
        mcpe_pkg::KIND_SUB, mcpe_pkg::KIND_UNSUB, mcpe_pkg::KIND_PUB: begin
          cmd_wr = 1'b1;
          if (packet_kind_i == mcpe_pkg::KIND_SUB) begin
            cmd.head = mcpe_pkg::H_SUB;
            cmd.rem  = mcpe_pkg::mcpe_rem_t'(5) + r1;
          end else if (packet_kind_i == mcpe_pkg::KIND_UNSUB) begin
            cmd.head = mcpe_pkg::H_UNSUB;
            cmd.rem  = mcpe_pkg::mcpe_rem_t'(4) + r1;
          end else begin
            cmd.head = mcpe_pkg::H_PUB;
            cmd.rem  = mcpe_pkg::mcpe_rem_t'((qos_sat != 2'd0) ? 3'd4 : 3'd2) + r1 + r2;
          end
          if (first_len_i != '0) begin
            phase_d = PH_TOPIC;
            left_d  = first_len_i;
          end else begin
            s_ph       = PH_TOPIC;
            use_settle = 1'b1;
          end
        end
        mcpe_pkg::KIND_DISC: begin
          cmd.head = mcpe_pkg::H_DISC;
          cmd.last = 1'b1;
          cmd_wr   = 1'b1;
        end
        mcpe_pkg::KIND_PING: begin
          cmd.head = mcpe_pkg::H_PING;
          cmd.last = 1'b1;
          cmd_wr   = 1'b1;
        end
        default: ;  // unknown kind: nothing sent, block goes idle
      endcase
    end else if (phase_q == PH_IDLE) begin
      cmd.head = mcpe_pkg::H_ERR;
      cmd_wr   = 1'b1;
    end else begin
      cmd.head  = mcpe_pkg::H_DATA;
      cmd.dbyte = data_byte_i;
      cmd_wr    = 1'b1;
      left_d    = left_m;
      if (left_m == '0) begin
        s_ph       = phase_q;
        use_settle = 1'b1;
      end
    end

    cmd.qos = s_qos;
    cmd.pid = pid_q;
    if (use_settle) begin
      phase_d     = s_ph_next;
      left_d      = s_left;
      cmd.ext_en  = s_ext_en;
      cmd.ext_len = s_ext_len;
      cmd.qos_en  = s_qos_en;
      cmd.pid_en  = s_pid_en;
      cmd.last    = s_last;
      if (s_pid_en) begin
        pid_d = pid_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      kind_q  <= '0;
      left_q  <= '0;
      sec_q   <= '0;
      thr_q   <= '0;
      qos_q   <= '0;
      pid_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      left_q  <= left_d;
      sec_q   <= sec_d;
      thr_q   <= thr_d;
      qos_q   <= qos_d;
      pid_q   <= pid_d;
    end
  end

  assign cmd_wr_o = accept_i && cmd_wr;
  assign cmd_o    = cmd;

endmodule

`default_nettype wire

// ===== hw/rtl/mcpe_cmd_queue.sv =====
// Command queue between the front and the back end of the packet encoder.
// Depends on mcpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcpe_cmd_queue (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      wr_i,
  input  wire  mcpe_pkg::mcpe_cmd_t wdata_i,
  output logic                     full_o,
  input  wire                      rd_i,
  output logic                     valid_o,
  output mcpe_pkg::mcpe_cmd_t      rdata_o
);

  mcpe_pkg::mcpe_cmd_t  mem_q [mcpe_pkg::CMD_DEPTH];
  mcpe_pkg::mcpe_qptr_t wptr_q, rptr_q;
  mcpe_pkg::mcpe_qcnt_t cnt_q, cnt_d;
  logic                 do_wr, do_rd;

  assign do_wr = wr_i && !full_o;
  assign do_rd = rd_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign full_o  = (cnt_q == mcpe_pkg::CMD_FULL);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

endmodule

`default_nettype wire

// ===== hw/rtl/mcpe_back.sv =====
// Back end: walks each command byte by byte and feeds a two-entry output buffer.
// Depends on mcpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcpe_back (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cmd_valid_i,
  input  wire  mcpe_pkg::mcpe_cmd_t cmd_i,
  output logic                     cmd_pop_o,
  input  wire  mcpe_pkg::mcpe_cfg_t cfg_i,
  input  wire                      pop_i,
  output logic                     empty_o,
  output logic [7:0]               out_byte_o,
  output logic                     last_o,
  output logic                     error_o
);

  typedef enum logic [3:0] {
    SEG_HEAD,
    SEG_REM,
    SEG_PROTO,
    SEG_P1_HI,
    SEG_P1_LO,
    SEG_EX_HI,
    SEG_EX_LO,
    SEG_QOS,
    SEG_PID_HI,
    SEG_PID_LO,
    SEG_DONE
  } seg_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } out_ent_t;

  localparam logic [7:0] PROTO_LEVEL = 8'h04;
  localparam logic [3:0] PROTO_TOP_CONN = 4'd9;  // 00 04 M Q T T 04 flags ka ka
  localparam logic [3:0] PROTO_TOP_SUB  = 4'd1;  // 00 01 packet id
  localparam logic [1:0] OUT_DEPTH = 2'd2;

  mcpe_pkg::mcpe_cmd_t cur_q;
  logic                cur_v_q;
  seg_e                seg_q, seg_d;
  logic [3:0]          cnt_q, cnt_d;

  logic [20:0]         rem_w;
  logic [1:0]          rem_top;
  logic [3:0]          proto_top;
  logic [15:0]         p1_w, ex_w;
  seg_e                tail_ex, tail_qos, tail_pid;
  logic [7:0]          byte_c;
  logic                final_c, emit;

  out_ent_t            buf_q [OUT_DEPTH];
  logic                bw_q, br_q;
  logic [1:0]          bcnt_q;
  logic                brd, space;

  assign rem_w   = 21'(cur_q.rem);
  assign rem_top = (rem_w[20:14] != '0) ? 2'd2 : ((rem_w[20:7] != '0) ? 2'd1 : 2'd0);
  assign proto_top = (cur_q.head == mcpe_pkg::H_CONN) ? PROTO_TOP_CONN : PROTO_TOP_SUB;
  assign p1_w    = 16'(cur_q.len1);
  assign ex_w    = 16'(cur_q.ext_len);

  assign tail_pid = cur_q.pid_en ? SEG_PID_HI : SEG_DONE;
  assign tail_qos = cur_q.qos_en ? SEG_QOS : tail_pid;
  assign tail_ex  = cur_q.ext_en ? SEG_EX_HI : tail_qos;

  // next segment
  always_comb begin
    seg_d = SEG_DONE;
    cnt_d = '0;
    unique case (seg_q)
      SEG_HEAD: begin
        unique case (cur_q.head) inside
          mcpe_pkg::H_ERR, mcpe_pkg::H_DATA: seg_d = tail_ex;
          default:                           seg_d = SEG_REM;
        endcase
      end
      SEG_REM: begin
        if (cnt_q[1:0] != rem_top) begin
          seg_d = SEG_REM;
          cnt_d = cnt_q + 1'b1;
        end else begin
          unique case (cur_q.head) inside
            mcpe_pkg::H_CONN, mcpe_pkg::H_SUB, mcpe_pkg::H_UNSUB: seg_d = SEG_PROTO;
            mcpe_pkg::H_PUB:                                      seg_d = SEG_P1_HI;
            default:                                              seg_d = tail_ex;
          endcase
        end
      end
      SEG_PROTO: begin
        if (cnt_q != proto_top) begin
          seg_d = SEG_PROTO;
          cnt_d = cnt_q + 1'b1;
        end else begin
          seg_d = SEG_P1_HI;
        end
      end
      SEG_P1_HI:  seg_d = SEG_P1_LO;
      SEG_P1_LO:  seg_d = tail_ex;
      SEG_EX_HI:  seg_d = SEG_EX_LO;
      SEG_EX_LO:  seg_d = tail_qos;
      SEG_QOS:    seg_d = tail_pid;
      SEG_PID_HI: seg_d = SEG_PID_LO;
      default:    seg_d = SEG_DONE;
    endcase
  end

  // byte of the current segment
  always_comb begin
    byte_c = 8'h00;
    unique case (seg_q)
      SEG_HEAD: begin
        unique case (cur_q.head)
          mcpe_pkg::H_CONN:  byte_c = mcpe_pkg::HDR_CONNECT;
          mcpe_pkg::H_SUB:   byte_c = mcpe_pkg::HDR_SUB;
          mcpe_pkg::H_UNSUB: byte_c = mcpe_pkg::HDR_UNSUB;
          mcpe_pkg::H_PUB:   byte_c = mcpe_pkg::HDR_PUB | {5'b0, cur_q.qos, 1'b0};
          mcpe_pkg::H_DISC:  byte_c = mcpe_pkg::HDR_DISC;
          mcpe_pkg::H_PING:  byte_c = mcpe_pkg::HDR_PING;
          mcpe_pkg::H_DATA:  byte_c = cur_q.dbyte;
          default:           byte_c = 8'h00;
        endcase
      end
      SEG_REM: begin
        // continuation bit on every group but the last
        case (cnt_q[1:0])
          2'd0:    byte_c = {1'b0, rem_w[6:0]};
          2'd1:    byte_c = {1'b0, rem_w[13:7]};
          default: byte_c = {1'b0, rem_w[20:14]};
        endcase
        byte_c[7] = (cnt_q[1:0] != rem_top);
      end
      SEG_PROTO: begin
        case (cnt_q)
          4'd0:    byte_c = 8'h00;
          4'd1:    byte_c = (cur_q.head == mcpe_pkg::H_CONN) ? PROTO_LEVEL : 8'h01;
          4'd2:    byte_c = 8'h4D;  // M
          4'd3:    byte_c = 8'h51;  // Q
          4'd4:    byte_c = 8'h54;  // T
          4'd5:    byte_c = 8'h54;  // T
          4'd6:    byte_c = PROTO_LEVEL;
          4'd7:    byte_c = cfg_i.flags;
          4'd8:    byte_c = cfg_i.keep_alive[15:8];
          default: byte_c = cfg_i.keep_alive[7:0];
        endcase
      end
      SEG_P1_HI:  byte_c = p1_w[15:8];
      SEG_P1_LO:  byte_c = p1_w[7:0];
      SEG_EX_HI:  byte_c = ex_w[15:8];
      SEG_EX_LO:  byte_c = ex_w[7:0];
      SEG_QOS:    byte_c = {6'b0, cur_q.qos};
      SEG_PID_HI: byte_c = cur_q.pid[15:8];
      SEG_PID_LO: byte_c = cur_q.pid[7:0];
      default:    byte_c = 8'h00;
    endcase
  end

  assign final_c   = (seg_d == SEG_DONE);
  assign brd       = pop_i && (bcnt_q != 2'd0);
  assign space     = (bcnt_q != OUT_DEPTH) || brd;
  assign emit      = cur_v_q && space;
  // load the next command when none is held or as the current one sends its final byte
  assign cmd_pop_o = cmd_valid_i && (!cur_v_q || (emit && final_c));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      seg_q   <= SEG_HEAD;
      cnt_q   <= '0;
    end else if (cmd_pop_o) begin
      cur_v_q <= 1'b1;
      seg_q   <= SEG_HEAD;
      cnt_q   <= '0;
    end else if (emit) begin
      cur_v_q <= !final_c;
      seg_q   <= seg_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
  end

  // output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q   <= 1'b0;
      br_q   <= 1'b0;
      bcnt_q <= '0;
    end else begin
      if (emit) begin
        bw_q <= ~bw_q;
      end
      if (brd) begin
        br_q <= ~br_q;
      end
      if (emit && !brd) begin
        bcnt_q <= bcnt_q + 1'b1;
      end else if (brd && !emit) begin
        bcnt_q <= bcnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      buf_q[bw_q] <= '{data: byte_c,
                       last: cur_q.last && final_c,
                       err:  (cur_q.head == mcpe_pkg::H_ERR)};
    end
  end

  assign empty_o    = (bcnt_q == 2'd0);
  assign out_byte_o = buf_q[br_q].data;
  assign last_o     = buf_q[br_q].last;
  assign error_o    = buf_q[br_q].err;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for mqtt_control_packet_encoder: directed and random start/data
// items against a cycle-free predictor of the encoded byte stream, with random idling.
// Depends on mcpe_pkg and the encoder RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int RAND_ITEMS   = 300;

  localparam logic [2:0] KIND_BAD_LO = 3'd6;
  localparam logic [2:0] KIND_BAD_HI = 3'd7;
  localparam logic [7:0] PROTO_LEVEL = 8'h04;
  localparam logic [15:0] PROTO_NAME_LEN = 16'h0004;
  localparam logic [15:0] FIXED_PKT_ID = 16'h0001;

  typedef enum logic [2:0] {ST_IDLE, ST_CID, ST_USER, ST_PASS, ST_TOPIC, ST_MSG} enc_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } enc_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic req_type = 1'b0;
  logic [2:0] packet_kind = '0;
  mcpe_pkg::mcpe_len_t first_len = '0;
  mcpe_pkg::mcpe_len_t second_len = '0;
  mcpe_pkg::mcpe_len_t third_len = '0;
  logic [1:0] qos_level = '0;
  logic [7:0] data_byte = '0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] out_byte;
  logic out_last;
  logic out_error;
  logic cfg_we = 1'b0;
  logic [mcpe_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [mcpe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // shared run state
  logic idle_on = 1'b1;
  logic rx_hold_req = 1'b0;
  int rx_hold_left = 0;
  int fail_count = 0;
  int items_taken = 0;
  enc_byte_t exp_bytes[$];
  enc_byte_t step_bytes[$];

  // predictor state
  logic [15:0]         pr_keep_alive = 16'd60;
  logic [7:0]          pr_flags = 8'hC2;
  enc_phase_e          pr_phase = ST_IDLE;
  logic [2:0]          pr_kind = '0;
  mcpe_pkg::mcpe_len_t pr_left = '0;
  mcpe_pkg::mcpe_len_t pr_user_len = '0;
  mcpe_pkg::mcpe_len_t pr_pass_len = '0;
  logic [1:0]          pr_qos = '0;
  logic [15:0]         pr_pub_id = '0;

  mqtt_control_packet_encoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .req_type_i    (req_type),
    .packet_kind_i (packet_kind),
    .first_len_i   (first_len),
    .second_len_i  (second_len),
    .third_len_i   (third_len),
    .qos_level_i   (qos_level),
    .data_byte_i   (data_byte),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte),
    .last_o        (out_last),
    .error_o       (out_error),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // ---------------- predictor ----------------
  function automatic void emit(logic [7:0] b);
    step_bytes.push_back('{data: b, last: 1'b0, err: 1'b0});
  endfunction

  function automatic void emit16(logic [15:0] v);
    emit(v[15:8]);
    emit(v[7:0]);
  endfunction

  function automatic void emit_remlen(int unsigned v);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      emit(b);
    end while (v != 0);
  endfunction

  function automatic void close_packet();
    if (step_bytes.size() > 0) step_bytes[$].last = 1'b1;
    pr_phase = ST_IDLE;
  endfunction

  function automatic void open_string(enc_phase_e ph, mcpe_pkg::mcpe_len_t len);
    emit16(len);
    pr_phase = ph;
    pr_left = len;
  endfunction

  // walk past every string that is already complete
  function automatic void skip_done_strings();
    while (pr_phase != ST_IDLE && pr_left == 0) begin
      case (pr_phase)
        ST_CID: begin
          if (pr_user_len != 0) open_string(ST_USER, pr_user_len);
          else pr_phase = ST_USER;
        end
        ST_USER: begin
          if (pr_pass_len != 0) open_string(ST_PASS, pr_pass_len);
          else close_packet();
        end
        ST_TOPIC: begin
          if (pr_kind == mcpe_pkg::KIND_SUB) begin
            emit({6'd0, pr_qos});
            close_packet();
          end else if (pr_kind == mcpe_pkg::KIND_PUB) begin
            if (pr_qos != 0) begin
              emit16(pr_pub_id);
              pr_pub_id = pr_pub_id + 16'd1;
            end
            pr_phase = ST_MSG;
            pr_left = pr_user_len;
            if (pr_left == 0) close_packet();
          end else begin
            close_packet();
          end
        end
        default: close_packet();
      endcase
    end
  endfunction

  function automatic void open_packet(logic [2:0] kind, mcpe_pkg::mcpe_len_t l1,
                                      mcpe_pkg::mcpe_len_t l2, mcpe_pkg::mcpe_len_t l3,
                                      logic [1:0] q);
    int unsigned rem, a, b, c;
    a = l1;
    b = l2;
    c = l3;
    pr_kind = kind;
    pr_qos = (q == 2'd3) ? 2'd2 : q;
    pr_user_len = l2;
    pr_pass_len = l3;
    pr_phase = ST_IDLE;
    pr_left = '0;
    case (kind) inside
      mcpe_pkg::KIND_CONNECT: begin
        rem = 12 + a + ((b != 0) ? b + 2 : 0) + ((c != 0) ? c + 2 : 0);
        emit(mcpe_pkg::HDR_CONNECT);
        emit_remlen(rem);
        emit16(PROTO_NAME_LEN);
        emit("M");
        emit("Q");
        emit("T");
        emit("T");
        emit(PROTO_LEVEL);
        emit(pr_flags);
        emit16(pr_keep_alive);
        open_string(ST_CID, l1);
        skip_done_strings();
      end
      mcpe_pkg::KIND_SUB, mcpe_pkg::KIND_UNSUB: begin
        rem = 4 + a + ((kind == mcpe_pkg::KIND_SUB) ? 1 : 0);
        emit((kind == mcpe_pkg::KIND_SUB) ? mcpe_pkg::HDR_SUB : mcpe_pkg::HDR_UNSUB);
        emit_remlen(rem);
        emit16(FIXED_PKT_ID);
        open_string(ST_TOPIC, l1);
        skip_done_strings();
      end
      mcpe_pkg::KIND_PUB: begin
        rem = 2 + a + ((pr_qos != 0) ? 2 : 0) + b;
        emit(mcpe_pkg::HDR_PUB | {5'd0, pr_qos, 1'b0});
        emit_remlen(rem);
        open_string(ST_TOPIC, l1);
        skip_done_strings();
      end
      mcpe_pkg::KIND_DISC: begin
        emit(mcpe_pkg::HDR_DISC);
        emit(8'h00);
        close_packet();
      end
      mcpe_pkg::KIND_PING: begin
        emit(mcpe_pkg::HDR_PING);
        emit(8'h00);
        close_packet();
      end
      default: ;  // unknown kind: silently back to idle
    endcase
  endfunction

  function automatic void encode_item(logic rt, logic [2:0] kind, mcpe_pkg::mcpe_len_t l1,
                                      mcpe_pkg::mcpe_len_t l2, mcpe_pkg::mcpe_len_t l3,
                                      logic [1:0] q, logic [7:0] d);
    step_bytes.delete();
    if (!rt) begin
      open_packet(kind, l1, l2, l3, q);
    end else if (pr_phase == ST_IDLE) begin
      step_bytes.push_back('{data: 8'h00, last: 1'b0, err: 1'b1});
    end else begin
      emit(d);
      pr_left = pr_left - 1'b1;
      skip_done_strings();
    end
    foreach (step_bytes[i]) exp_bytes.push_back(step_bytes[i]);
  endfunction

  function automatic int unsigned string_bytes(logic [2:0] kind, mcpe_pkg::mcpe_len_t l1,
                                               mcpe_pkg::mcpe_len_t l2,
                                               mcpe_pkg::mcpe_len_t l3);
    int unsigned a, b, c;
    a = l1;
    b = l2;
    c = l3;
    case (kind) inside
      mcpe_pkg::KIND_CONNECT:                   return a + b + c;
      mcpe_pkg::KIND_SUB, mcpe_pkg::KIND_UNSUB: return a;
      mcpe_pkg::KIND_PUB:                       return a + b;
      default:                                  return 0;
    endcase
  endfunction

  function automatic mcpe_pkg::mcpe_len_t pick_len();
    if ($urandom_range(99) < 80) return mcpe_pkg::mcpe_len_t'($urandom_range(0, 4));
    return mcpe_pkg::mcpe_len_t'($urandom_range(5, 24));
  endfunction

  // ---------------- drivers ----------------
  task automatic push_item(input logic rt, input logic [2:0] kind,
                           input mcpe_pkg::mcpe_len_t l1, input mcpe_pkg::mcpe_len_t l2,
                           input mcpe_pkg::mcpe_len_t l3, input logic [1:0] q,
                           input logic [7:0] d);
    int gap;
    gap = 0;
    while (idle_on && $urandom_range(99) < 32) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    req_type <= rt;
    packet_kind <= kind;
    first_len <= l1;
    second_len <= l2;
    third_len <= l3;
    qos_level <= q;
    data_byte <= d;
    do @(posedge clk_i); while (full);
    encode_item(rt, kind, l1, l2, l3, q, d);
    items_taken++;
  endtask

  task automatic send_start(input logic [2:0] kind, input mcpe_pkg::mcpe_len_t l1,
                            input mcpe_pkg::mcpe_len_t l2, input mcpe_pkg::mcpe_len_t l3,
                            input logic [1:0] q);
    push_item(1'b0, kind, l1, l2, l3, q, 8'($urandom));
  endtask

  // other fields are don't-care on a data item, so fill them with noise
  task automatic send_data(input logic [7:0] d);
    push_item(1'b1, 3'($urandom), mcpe_pkg::mcpe_len_t'($urandom),
              mcpe_pkg::mcpe_len_t'($urandom), mcpe_pkg::mcpe_len_t'($urandom),
              2'($urandom), d);
  endtask

  // cut < 0 sends every string byte, otherwise at most cut of them
  task automatic send_packet(input logic [2:0] kind, input mcpe_pkg::mcpe_len_t l1,
                             input mcpe_pkg::mcpe_len_t l2, input mcpe_pkg::mcpe_len_t l3,
                             input logic [1:0] q, input int cut);
    int unsigned n;
    n = string_bytes(kind, l1, l2, l3);
    if (cut >= 0 && n > cut) n = cut;
    send_start(kind, l1, l2, l3, q);
    for (int unsigned i = 0; i < n; i++) send_data(8'($urandom));
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (exp_bytes.size() != 0) @(posedge clk_i);
    // an item with no output may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mcpe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mcpe_pkg::CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    if (idx == mcpe_pkg::CFG_KEEP_ALIVE) pr_keep_alive = v;
    else pr_flags = v[7:0];
  endtask

  // ---------------- receiver and checker ----------------
  always @(posedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= idle_on ? ($urandom_range(99) >= 32) : 1'b1;
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_result
    enc_byte_t want;
    if (rst_ni && pop && !empty) begin
      if (exp_bytes.size() == 0) begin
        $display("%0t: unexpected item, expected none, got byte %02h last %0b error %0b",
                 $time, out_byte, out_last, out_error);
        fail_count++;
      end else begin
        want = exp_bytes.pop_front();
        check_field("out_byte", want.data, out_byte);
        check_field("last", want.last, out_last);
        check_field("error", want.err, out_error);
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    send_packet(mcpe_pkg::KIND_CONNECT, 0, 0, 0, 2'd0, -1);   // reset config, empty strings
    send_packet(mcpe_pkg::KIND_CONNECT, 2, 1, 1, 2'd0, -1);
    send_packet(mcpe_pkg::KIND_SUB, 1, 0, 0, 2'd0, -1);
    send_packet(mcpe_pkg::KIND_SUB, 0, 0, 0, 2'd3, -1);       // QoS three acts as two
    send_packet(mcpe_pkg::KIND_UNSUB, 1, 0, 0, 2'd1, -1);
    send_packet(mcpe_pkg::KIND_PUB, 1, 1, 0, 2'd1, -1);
    send_packet(mcpe_pkg::KIND_PUB, 0, 0, 0, 2'd0, -1);
    send_packet(mcpe_pkg::KIND_PUB, 0, 1, 0, 2'd3, -1);
    send_packet(mcpe_pkg::KIND_DISC, 0, 0, 0, 2'd0, -1);
    send_packet(mcpe_pkg::KIND_PING, 0, 0, 0, 2'd0, -1);
    send_data(8'hFF);                                          // stray byte while idle
    send_start(KIND_BAD_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
    send_data(8'h00);
    send_start(KIND_BAD_HI, 0, 0, 0, 2'd0);
    // largest lengths, each packet abandoned by the next start
    send_packet(mcpe_pkg::KIND_CONNECT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3, 1);
    send_packet(mcpe_pkg::KIND_PUB, 16'hFFFF, 16'hFFFF, 0, 2'd2, 0);
    send_packet(mcpe_pkg::KIND_SUB, 16'hFFFF, 0, 0, 2'd1, 0);
    send_packet(mcpe_pkg::KIND_PING, 0, 0, 0, 2'd0, -1);
    wait_idle();
  endtask

  task automatic test_config();
    write_reg(mcpe_pkg::CFG_KEEP_ALIVE, 16'h0000);
    write_reg(mcpe_pkg::CFG_FLAGS, 16'h0000);
    send_packet(mcpe_pkg::KIND_CONNECT, 1, 0, 2, 2'd0, -1);
    wait_idle();
    write_reg(mcpe_pkg::CFG_KEEP_ALIVE, 16'hFFFF);
    write_reg(mcpe_pkg::CFG_FLAGS, 16'hFFFF);
    send_packet(mcpe_pkg::KIND_CONNECT, 1, 2, 0, 2'd0, -1);
    wait_idle();
    write_reg(mcpe_pkg::CFG_KEEP_ALIVE, 16'h1234);
    write_reg(mcpe_pkg::CFG_FLAGS, 16'h00A5);
    send_packet(mcpe_pkg::KIND_CONNECT, 0, 1, 1, 2'd0, -1);
    wait_idle();
  endtask

  // receiver stalls while the sender keeps offering, so the input side backs up
  task automatic test_backpressure();
    idle_on = 1'b0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_packet(mcpe_pkg::KIND_PUB, 2, 3, 0, 2'($urandom), -1);
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic send_random_packet();
    int r;
    r = $urandom_range(99);
    if (r < 80) begin
      send_packet(3'($urandom_range(0, 5)), pick_len(), pick_len(), pick_len(),
                  2'($urandom), -1);
    end else if (r < 87) begin
      send_data(8'($urandom));
    end else if (r < 92) begin
      send_start(($urandom_range(1) != 0) ? KIND_BAD_HI : KIND_BAD_LO,
                 mcpe_pkg::mcpe_len_t'($urandom), mcpe_pkg::mcpe_len_t'($urandom),
                 mcpe_pkg::mcpe_len_t'($urandom), 2'($urandom));
    end else begin
      send_packet(3'($urandom_range(0, 3)), mcpe_pkg::mcpe_len_t'($urandom),
                  mcpe_pkg::mcpe_len_t'($urandom), mcpe_pkg::mcpe_len_t'($urandom),
                  2'($urandom), $urandom_range(0, 3));
    end
  endtask

  task automatic test_random();
    int target;
    for (int ph = 0; ph < 6; ph++) begin
      idle_on = (ph != 2);   // one phase runs flat out on both sides
      write_reg(mcpe_pkg::CFG_KEEP_ALIVE, 16'($urandom));
      write_reg(mcpe_pkg::CFG_FLAGS, 16'($urandom));
      target = items_taken + RAND_ITEMS / 6;
      while (items_taken < target) send_random_packet();
      wait_idle();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config();
    test_backpressure();
    test_random();
    if (fail_count == 0) begin
      $display("mqtt_control_packet_encoder test passed");
    end else begin
      $display("mqtt_control_packet_encoder test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("mqtt_control_packet_encoder test failed");
    $finish;
  end

endmodule
